### rtl/halton_subpixel_jitter_core_defines.svh
// assertion helpers for the jitter core rtl
`ifndef HALTON_SUBPIXEL_JITTER_CORE_DEFINES_SVH
`define HALTON_SUBPIXEL_JITTER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define HSJ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define HSJ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/hsj_pkg.sv
package hsj_pkg;

  // defaults for the top level parameters
  localparam int SEQUENCE_BITS_DEF = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int FRAME_W = 32;
  localparam int PIX_W   = 16;
  localparam int NDC_W   = 17;
  localparam int SIZE_W  = 15;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // register reset values
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);

  // register index, byte address bit 2
  typedef enum logic [0:0] {
    REG_RENDER_WIDTH  = 1'b0,
    REG_RENDER_HEIGHT = 1'b1
  } reg_idx_t;

  // pipeline control handed to the sub-blocks
  typedef struct packed {
    logic en;
    logic valid;
  } hsj_ctl_t;

  // smallest digit count d with 3^d > 2^bits
  function automatic int digits3(input int bits);
    logic [127:0] p;
    logic [127:0] lim;
    int d;
    p = 128'd1;
    lim = 128'd1 << bits;
    d = 0;
    for (int i = 0; i < 82; i++) begin
      if (p <= lim) begin
        p = p * 128'd3;
        d = d + 1;
      end
    end
    return d;
  endfunction

endpackage

### rtl/hsj_in_if.sv
interface hsj_in_if import hsj_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_number;

  modport source (output valid, output frame_number, input ready);
  modport sink (input valid, input frame_number, output ready);
endinterface

### rtl/hsj_out_if.sv
interface hsj_out_if import hsj_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_jitter_x;
  logic signed [PIX_W-1:0] pixel_jitter_y;
  logic signed [NDC_W-1:0] ndc_jitter_x;
  logic signed [NDC_W-1:0] ndc_jitter_y;

  modport source (output valid, output pixel_jitter_x, output pixel_jitter_y,
                  output ndc_jitter_x, output ndc_jitter_y, input ready);
  modport sink (input valid, input pixel_jitter_x, input pixel_jitter_y,
                input ndc_jitter_x, input ndc_jitter_y, output ready);
endinterface

### rtl/halton_subpixel_jitter_core.sv
// halton sub-pixel jitter core
// in_ch carries a frame number; out_ch returns one item per input: the
// base-2 and base-3 halton values of frame_number + 1 minus one half, as
// signed fixed point pixel jitter, and the same scaled to normalized device
// units as 2 * jitter / render size (zero when either size is zero).
// render_width sits at byte address 0 and render_height at 4 on the apb
// port; write them only while no item is in flight.
// the datapath is a fully pipelined chain: one input register, D * C stages
// of the divide-by-three digit extractor (D base-3 digits, C = 16-bit slices
// of the sequence + 1), D horner stages, ceil((F + 1) / 4) divider stages and
// an output register.
// an item can be taken every cycle unless a shown result is held back; the rate is one item per clock.
// reset empties the pipeline and reloads the size registers with 1920 and
// 1080. when the receiver drops ready while a result is shown, the whole
// pipeline holds in place and in_ch.ready falls; nothing is lost or repeated.
`include "halton_subpixel_jitter_core_defines.svh"

module halton_subpixel_jitter_core import hsj_pkg::*; #(
  parameter int SEQUENCE_BITS = SEQUENCE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  hsj_in_if.sink            in_ch,
  hsj_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int W  = SEQUENCE_BITS + 1;
  localparam int F  = FRACTION_BITS;
  localparam int EW = (W > F) ? W : F;

  logic [SIZE_W-1:0]        width_r;
  logic [SIZE_W-1:0]        height_r;
  logic                     en;
  logic [SEQUENCE_BITS-1:0] seq;
  logic [W-1:0]             sample;
  logic [F-1:0]             rev;
  logic                     s0_valid;
  logic [W-1:0]             s0_sample;
  logic [F-1:0]             s0_px;
  hsj_ctl_t                 r3_ctl;
  hsj_ctl_t                 dv_ctl;
  logic                     r3_valid;
  logic [F-1:0]             r3_h3;
  logic [F-1:0]             r3_px;
  logic [F-1:0]             py;
  reg_idx_t                 reg_idx;

  // config registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_RENDER_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_RENDER_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        default:           width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RENDER_WIDTH:  prdata = DATA_W'(width_r);
      REG_RENDER_HEIGHT: prdata = DATA_W'(height_r);
      default:           prdata = '0;
    endcase
  end

  // global advance: move unless a shown result is held back
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // sample = sequence + 1, one bit wider
  assign seq    = SEQUENCE_BITS'(in_ch.frame_number);
  assign sample = W'(seq) + W'(1);

  // base-2 radical inverse is the bit reversal of the low bits
  always_comb begin : bit_rev
    logic [EW-1:0] ext;
    ext = EW'(sample);
    for (int j = 0; j < F; j++) begin
      rev[F-1-j] = ext[j];
    end
  end

  // input register; minus one half flips the top fraction bit
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_sample <= sample;
      s0_px     <= {~rev[F-1], rev[F-2:0]};
    end
  end

  // base-3 radical inverse
  assign r3_ctl = '{en: en, valid: s0_valid};

  hsj_radix3 #(
    .SEQUENCE_BITS (SEQUENCE_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .TAG_W         (F)
  ) u_radix3 (
    .clk       (clk),
    .rst       (rst),
    .ctl       (r3_ctl),
    .in_sample (s0_sample),
    .in_tag    (s0_px),
    .out_valid (r3_valid),
    .out_h3    (r3_h3),
    .out_tag   (r3_px)
  );

  assign py = {~r3_h3[F-1], r3_h3[F-2:0]};

  // normalized device scaling and output register
  assign dv_ctl = '{en: en, valid: r3_valid};

  hsj_ndc_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ndc_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (dv_ctl),
    .in_px     (r3_px),
    .in_py     (py),
    .width     (width_r),
    .height    (height_r),
    .out_valid (out_ch.valid),
    .pix_x     (out_ch.pixel_jitter_x),
    .pix_y     (out_ch.pixel_jitter_y),
    .ndc_x     (out_ch.ndc_jitter_x),
    .ndc_y     (out_ch.ndc_jitter_y)
  );

  // checks
  `HSJ_ASSERT_NOW(a_zero_size_ndc, out_ch.valid && (width_r == '0 || height_r == '0), out_ch.ndc_jitter_x == '0 && out_ch.ndc_jitter_y == '0, "ndc jitter not zero with a zero render size")
  `HSJ_ASSERT_NOW(a_out_rise_on_advance, $rose(out_ch.valid), $past(en), "result appeared while the pipeline was held")
  `HSJ_ASSERT_NEXT(a_stall_keeps_item, s0_valid && !en, s0_valid, "item dropped from the input register during a stall")

endmodule

### rtl/hsj_radix3.sv
module hsj_radix3 import hsj_pkg::*; #(
  parameter int SEQUENCE_BITS = SEQUENCE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int TAG_W         = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  hsj_ctl_t                 ctl,
  input  logic [SEQUENCE_BITS:0]   in_sample,
  input  logic [TAG_W-1:0]         in_tag,
  output logic                     out_valid,
  output logic [FRACTION_BITS-1:0] out_h3,
  output logic [TAG_W-1:0]         out_tag
);

  localparam int W   = SEQUENCE_BITS + 1;
  localparam int CH  = 16;
  localparam int C   = (W + CH - 1) / CH;
  localparam int WP  = C * CH;
  localparam int D   = digits3(SEQUENCE_BITS);
  localparam int NS  = D * C;
  localparam int RT  = NS + D;
  localparam int F   = FRACTION_BITS;
  localparam int N   = F + 2;
  localparam int K   = N + 1;
  localparam logic [K-1:0] MUL = K'(((64'd1 << K) / 3) + 64'd1);

  logic               vld_q  [RT];
  logic [TAG_W-1:0]   tag_q  [RT];
  logic [WP-1:0]      cur_q  [NS];
  logic [1:0]         rem_q  [NS];
  logic [2*D-1:0]     dig_q  [NS];
  logic [2*D-1:0]     hdig_q [D];
  logic [F-1:0]       acc_q  [D];

  // valid and tag travel with the item
  for (genvar s = 0; s < RT; s++) begin : g_line
    logic             vld_in;
    logic [TAG_W-1:0] tag_in;
    if (s == 0) begin : g_first
      assign vld_in = ctl.valid;
      assign tag_in = in_tag;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign tag_in = tag_q[s-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (ctl.en) begin
        vld_q[s] <= vld_in;
      end
    end
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        tag_q[s] <= tag_in;
      end
    end
  end

  // base-3 digit extraction, one 16-bit slice of a divide by three per stage
  for (genvar s = 0; s < NS; s++) begin : g_digit
    localparam int I    = s / C;
    localparam int CC   = s % C;
    localparam int POS  = WP - 1 - CC * CH;
    localparam bit LAST = (CC == C - 1);
    logic [WP-1:0]  cur_in, cur_next;
    logic [1:0]     rem_in, rem_next;
    logic [2*D-1:0] dig_in, dig_next;
    if (s == 0) begin : g_first
      assign cur_in = WP'(in_sample);
      assign rem_in = 2'd0;
      assign dig_in = '0;
    end else begin : g_next
      assign cur_in = cur_q[s-1];
      assign rem_in = rem_q[s-1];
      assign dig_in = dig_q[s-1];
    end

    // radix-4 long division steps, quotient replaces the dividend bits
    always_comb begin : div_slice
      logic [3:0]    v;
      logic [1:0]    q;
      logic [1:0]    r;
      logic [WP-1:0] cv;
      logic [2*D-1:0] dg;
      cv = cur_in;
      r  = rem_in;
      dg = dig_in;
      for (int t = 0; t < CH / 2; t++) begin
        v = {r, cv[POS - 2*t -: 2]};
        q = (v >= 4'd9) ? 2'd3 : (v >= 4'd6) ? 2'd2 : (v >= 4'd3) ? 2'd1 : 2'd0;
        r = 2'(v - 4'(q) * 4'd3);
        cv[POS - 2*t -: 2] = q;
      end
      if (LAST) begin
        dg[2*I +: 2] = r;
        r = 2'd0;
      end
      cur_next = cv;
      rem_next = r;
      dig_next = dg;
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        cur_q[s] <= cur_next;
        rem_q[s] <= rem_next;
        dig_q[s] <= dig_next;
      end
    end
  end

  // horner from the deepest digit, acc = (d * 2^F + acc) / 3 per stage
  for (genvar h = 0; h < D; h++) begin : g_horner
    logic [2*D-1:0] dig_in;
    logic [F-1:0]   acc_in;
    logic [N-1:0]   v;
    logic [N+K-1:0] prod;
    if (h == 0) begin : g_first
      assign dig_in = dig_q[NS-1];
      assign acc_in = '0;
    end else begin : g_next
      assign dig_in = hdig_q[h-1];
      assign acc_in = acc_q[h-1];
    end
    // divide by three as a multiply by the rounded-up reciprocal
    assign v    = {dig_in[2*(D-1-h) +: 2], acc_in};
    assign prod = (N+K)'(v) * (N+K)'(MUL);

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        hdig_q[h] <= dig_in;
        acc_q[h]  <= prod[K +: F];
      end
    end
  end

  assign out_valid = vld_q[RT-1];
  assign out_h3    = acc_q[D-1];
  assign out_tag   = tag_q[RT-1];

endmodule

### rtl/hsj_ndc_div.sv
module hsj_ndc_div import hsj_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  hsj_ctl_t                 ctl,
  input  logic [FRACTION_BITS-1:0] in_px,
  input  logic [FRACTION_BITS-1:0] in_py,
  input  logic [SIZE_W-1:0]        width,
  input  logic [SIZE_W-1:0]        height,
  output logic                     out_valid,
  output logic signed [PIX_W-1:0]  pix_x,
  output logic signed [PIX_W-1:0]  pix_y,
  output logic signed [NDC_W-1:0]  ndc_x,
  output logic signed [NDC_W-1:0]  ndc_y
);

  localparam int F   = FRACTION_BITS;
  localparam int QB  = F + 1;
  localparam int BPS = 4;
  localparam int DS  = (QB + BPS - 1) / BPS;
  localparam int QP  = DS * BPS;
  localparam int RW  = SIZE_W + 1;

  logic                    vld_q [DS];
  logic [QP-1:0]           n_q   [2][DS];
  logic [RW-1:0]           r_q   [2][DS];
  logic                    neg_q [2][DS];
  logic [F-1:0]            p_q   [2][DS];
  logic signed [PIX_W-1:0] pix_q [2];
  logic signed [NDC_W-1:0] ndc_q [2];
  logic                    size_zero;

  assign size_zero = (width == '0) || (height == '0);

  // valid line
  for (genvar k = 0; k < DS; k++) begin : g_vld
    logic vld_in;
    if (k == 0) begin : g_first
      assign vld_in = ctl.valid;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (ctl.en) begin
        vld_q[k] <= vld_in;
      end
    end
  end

  // one restoring divider lane per axis, four quotient bits per stage
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [F-1:0]      p_lane;
    logic [SIZE_W-1:0] size;
    logic [QB-1:0]     dbl;
    logic [QB-1:0]     mag;
    logic [QB-1:0]     q;
    logic [QB:0]       sq;
    if (l == 0) begin : g_x
      assign p_lane = in_px;
      assign size   = width;
    end else begin : g_y
      assign p_lane = in_py;
      assign size   = height;
    end

    // magnitude of twice the jitter
    assign dbl = {p_lane, 1'b0};
    assign mag = p_lane[F-1] ? (~dbl + QB'(1)) : dbl;

    for (genvar k = 0; k < DS; k++) begin : g_stage
      localparam int TOP = QP - 1 - k * BPS;
      logic [QP-1:0] n_in, n_next;
      logic [RW-1:0] r_in, r_next;
      logic          neg_in;
      logic [F-1:0]  p_in;
      if (k == 0) begin : g_first
        assign n_in   = QP'(mag);
        assign r_in   = '0;
        assign neg_in = p_lane[F-1];
        assign p_in   = p_lane;
      end else begin : g_next
        assign n_in   = n_q[l][k-1];
        assign r_in   = r_q[l][k-1];
        assign neg_in = neg_q[l][k-1];
        assign p_in   = p_q[l][k-1];
      end

      // shift in a dividend bit, subtract the size where it fits
      always_comb begin : div_bits
        logic [RW-1:0] r;
        logic [QP-1:0] n;
        n = n_in;
        r = r_in;
        for (int t = 0; t < BPS; t++) begin
          r = {r[RW-2:0], n[TOP - t]};
          if (r >= RW'(size)) begin
            r = r - RW'(size);
            n[TOP - t] = 1'b1;
          end else begin
            n[TOP - t] = 1'b0;
          end
        end
        n_next = n;
        r_next = r;
      end

      always_ff @(posedge clk) begin
        if (ctl.en) begin
          n_q[l][k]   <= n_next;
          r_q[l][k]   <= r_next;
          neg_q[l][k] <= neg_in;
          p_q[l][k]   <= p_in;
        end
      end
    end

    // restore the sign, truncating toward zero
    assign q  = n_q[l][DS-1][QB-1:0];
    assign sq = neg_q[l][DS-1] ? (~{1'b0, q} + (QB+1)'(1)) : {1'b0, q};

    // output register
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        pix_q[l] <= PIX_W'($signed(p_q[l][DS-1]));
        ndc_q[l] <= size_zero ? '0 : NDC_W'($signed(sq));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.en) begin
      out_valid <= vld_q[DS-1];
    end
  end

  assign pix_x = pix_q[0];
  assign pix_y = pix_q[1];
  assign ndc_x = ndc_q[0];
  assign ndc_y = ndc_q[1];

endmodule

### sim/tb_top.sv
module tb_top;
  import hsj_pkg::*;

  // result fields of one item
  typedef struct {
    logic [PIX_W-1:0] pix_x;
    logic [PIX_W-1:0] pix_y;
    logic [NDC_W-1:0] ndc_x;
    logic [NDC_W-1:0] ndc_y;
  } jitter_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  hsj_in_if in_if();
  hsj_out_if out_if();

  halton_subpixel_jitter_core u_dut (
    .clk(clk), .rst(rst), .in_ch(in_if), .out_ch(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // testbench copy of the size registers
  logic [SIZE_W-1:0] cur_width = WIDTH_RESET;
  logic [SIZE_W-1:0] cur_height = HEIGHT_RESET;

  logic [FRAME_W-1:0] frame_queue[$];
  jitter_t jitter_queue[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cycles = 0;

  // floor(2^16 * base-3 radical inverse), exact nested floors
  function automatic logic [15:0] base3_fixed(input logic [32:0] sample);
    int digit[24];
    int n;
    longint unsigned v;
    longint unsigned acc;
    v = sample;
    n = 0;
    acc = 0;
    while (v != 0) begin
      digit[n] = int'(v % 3);
      v = v / 3;
      n++;
    end
    for (int i = n - 1; i >= 0; i--)
      acc = ((64'(digit[i]) << 16) + acc) / 3;
    return acc[15:0];
  endfunction

  // jitter pair and its ndc scaling for one frame number
  function automatic jitter_t jitter_of(input logic [FRAME_W-1:0] frame);
    jitter_t r;
    logic [32:0] sample;
    logic [15:0] rev;
    int px;
    int py;
    int nx;
    int ny;
    sample = {1'b0, frame} + 33'd1;
    for (int i = 0; i < 16; i++) rev[15-i] = sample[i];
    px = int'(rev) - 32768;
    py = int'(base3_fixed(sample)) - 32768;
    nx = 0;
    ny = 0;
    if (cur_width != 0 && cur_height != 0) begin
      nx = (2 * px) / int'(cur_width);
      ny = (2 * py) / int'(cur_height);
    end
    r.pix_x = px[PIX_W-1:0];
    r.pix_y = py[PIX_W-1:0];
    r.ndc_x = nx[NDC_W-1:0];
    r.ndc_y = ny[NDC_W-1:0];
    return r;
  endfunction

  // driver: feeds pending frames, predicts at acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      in_if.frame_number <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        jitter_queue.push_back(jitter_of(in_if.frame_number));
        items_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (frame_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.frame_number <= frame_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: compare each accepted item with the oldest prediction
  always @(posedge clk) begin
    jitter_t e;
    if (!rst && out_if.valid && out_if.ready) begin
      results_seen++;
      if (jitter_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item x=%0d y=%0d",
                                       out_if.pixel_jitter_x, out_if.pixel_jitter_y);
      end else begin
        e = jitter_queue.pop_front();
        if (out_if.pixel_jitter_x !== e.pix_x || out_if.pixel_jitter_y !== e.pix_y ||
            out_if.ndc_jitter_x !== e.ndc_x || out_if.ndc_jitter_y !== e.ndc_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp px=%h py=%h nx=%h ny=%h got px=%h py=%h nx=%h ny=%h",
                     e.pix_x, e.pix_y, e.ndc_x, e.ndc_y, out_if.pixel_jitter_x,
                     out_if.pixel_jitter_y, out_if.ndc_jitter_x, out_if.ndc_jitter_y);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d items outstanding", jitter_queue.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // apb write: setup then access
  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_RENDER_WIDTH) cur_width = val[SIZE_W-1:0];
    else cur_height = val[SIZE_W-1:0];
  endtask

  // wait until no item is queued, in flight or predicted
  task automatic wait_idle();
    @(posedge clk);
    while (frame_queue.size() > 0 || in_if.valid || jitter_queue.size() > 0)
      @(posedge clk);
  endtask

  task automatic set_sizes(input int w, input int h);
    wait_idle();
    reg_write(REG_RENDER_WIDTH, DATA_W'(w));
    reg_write(REG_RENDER_HEIGHT, DATA_W'(h));
  endtask

  // random frames: full range, small values, and values near powers
  task automatic push_random(input int n);
    logic [FRAME_W-1:0] f;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(3);
      case (kind)
        0: begin
          f = $urandom;
        end
        1: begin
          f = $urandom_range(4000);
        end
        2: begin
          f = FRAME_W'(longint'(3) ** $urandom_range(20)) - FRAME_W'($urandom_range(2));
        end
        default: begin
          f = (32'd1 << $urandom_range(31)) - FRAME_W'($urandom_range(2));
        end
      endcase
      frame_queue.push_back(f);
    end
  endtask

  int sizes_w[8] = '{1920, 0, 7, 16384, 1, 0, 3, 16384};
  int sizes_h[8] = '{1080, 5, 0, 16384, 1, 0, 2, 1};

  initial begin
    in_if.valid = 1'b0;
    in_if.frame_number = '0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset sizes, field extremes, sequence + 1 carrying into the extra bit
    frame_queue = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd7, 32'd8, 32'hFFFF_FFFF,
                    32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF,
                    32'h0001_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd25, 32'd26,
                    32'd242, 32'd59048, 32'd3486784400, 32'd1162261466};
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      if (p == 7) set_sizes($urandom_range(16384), $urandom_range(16384));
      else set_sizes(sizes_w[p], sizes_h[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      // sender holds off until every result has drained, once
      if (p == 1) begin
        push_random(20);
        wait_idle();
        push_random(130);
      end else begin
        push_random(154);
      end
    end
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d frame numbers over 8 size settings and 4 idle mixes", items_sent);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && jitter_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
